// ----- src/crsf_pkg.sv -----
// Shared types, register codes, reset values and the CRC-8 step for the CRSF frame detector.
package crsf_pkg;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W = 3;
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SYNC_LEAD      = 3'd0,
		CFG_RADIO_LEAD     = 3'd1,
		CFG_RECEIVER_LEAD  = 3'd2,
		CFG_MIN_LENGTH     = 3'd3,
		CFG_MAX_LENGTH     = 3'd4,
		CFG_WANTED_TYPE    = 3'd5,
		CFG_CRC_POLYNOMIAL = 3'd6
	} cfg_idx_t;

	// Register values after reset.
	localparam logic [7:0] RST_SYNC_LEAD      = 8'd200;
	localparam logic [7:0] RST_RADIO_LEAD     = 8'd234;
	localparam logic [7:0] RST_RECEIVER_LEAD  = 8'd236;
	localparam logic [7:0] RST_MIN_LENGTH     = 8'd2;
	localparam logic [7:0] RST_MAX_LENGTH     = 8'd62;
	localparam logic [7:0] RST_WANTED_TYPE    = 8'd22;
	localparam logic [7:0] RST_CRC_POLYNOMIAL = 8'd213;

	// Parser phase.
	typedef enum logic [1:0] {
		PH_HUNT   = 2'd0,
		PH_LENGTH = 2'd1,
		PH_DATA   = 2'd2
	} phase_t;

	// Per-item status code.
	typedef enum logic [2:0] {
		ST_PENDING    = 3'd0,
		ST_LEN_REJECT = 3'd1,
		ST_CRC_BAD    = 3'd2,
		ST_OTHER_TYPE = 3'd3,
		ST_DETECTED   = 3'd4
	} status_t;

	// One byte of CRC-8, MSB first, polynomial given without its top bit.
	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data,
			input logic [7:0] poly);
		logic [7:0] c;
		c = crc ^ data;
		for (int b = 0; b < 8; b++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ poly;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ----- src/crsf_ifs.sv -----
// Channel interfaces of the CRSF frame detector: received bytes, results and register writes.

// Received byte channel.
interface crsf_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// Result channel.
interface crsf_res_if import crsf_pkg::*; ();
	logic    valid;
	logic    ready;
	status_t status;
	logic    detected;

	modport source (output valid, output status, output detected, input ready);
	modport sink (input valid, input status, input detected, output ready);
endinterface

// Configuration write channel.
interface crsf_cfg_if import crsf_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [7:0]           data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- src/crsf_rc_frame_detector.sv -----
// Top level of the CRSF frame detector: input register, frame parser and result register.
//
//  channel | direction | payload                         | accepted when
//  rx      | in        | rx_byte[7:0]                    | rx.valid && rx.ready
//  res     | out       | status[2:0], detected           | res.valid && res.ready
//  cfg     | in        | index[2:0], data[7:0]           | cfg.valid && cfg.ready
//
// One byte per cycle sustained while results are taken. The byte goes into the input
// register, is parsed against the frame state once the result register is free or being
// drained, and the status lands in the result register.
// A stalled result holds the result register; the input register still takes one byte,
// after which rx.ready falls until the result is taken. Register writes are always ready.
// Reset returns the parser to hunting and loads the register defaults.
module crsf_rc_frame_detector import crsf_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	crsf_rx_if.sink         rx,
	crsf_res_if.source      res,
	crsf_cfg_if.sink        cfg
);

	// Configuration registers.
	logic [7:0] sync_lead_q, radio_lead_q, receiver_lead_q;
	logic [7:0] min_length_q, max_length_q, wanted_type_q, crc_poly_q;

	// Pipeline and frame state.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       out_valid_q;
	status_t    status_q;
	logic       detected_q;

	phase_t     phase_q, phase_d;
	logic [7:0] frame_len_q, frame_len_d;
	logic [7:0] seen_q, seen_d;
	logic [7:0] crc_q, crc_d;
	logic [7:0] first_q, first_d;
	status_t    status_d;
	logic       detected_d;

	logic       advance;
	logic       process;
	logic [7:0] type_byte;
	logic [7:0] seen_inc;

	// The parse stage moves when the result register is free or being drained.
	assign advance = !out_valid_q || res.ready;
	assign process = valid_s1 && advance;
	assign rx.ready = !valid_s1 || advance;
	assign cfg.ready = 1'b1;

	assign res.valid = out_valid_q;
	assign res.status = status_q;
	assign res.detected = detected_q;

	// Register writes; indexes past the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_lead_q     <= RST_SYNC_LEAD;
			radio_lead_q    <= RST_RADIO_LEAD;
			receiver_lead_q <= RST_RECEIVER_LEAD;
			min_length_q    <= RST_MIN_LENGTH;
			max_length_q    <= RST_MAX_LENGTH;
			wanted_type_q   <= RST_WANTED_TYPE;
			crc_poly_q      <= RST_CRC_POLYNOMIAL;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_SYNC_LEAD:      sync_lead_q     <= cfg.data;
				CFG_RADIO_LEAD:     radio_lead_q    <= cfg.data;
				CFG_RECEIVER_LEAD:  receiver_lead_q <= cfg.data;
				CFG_MIN_LENGTH:     min_length_q    <= cfg.data;
				CFG_MAX_LENGTH:     max_length_q    <= cfg.data;
				CFG_WANTED_TYPE:    wanted_type_q   <= cfg.data;
				CFG_CRC_POLYNOMIAL: crc_poly_q      <= cfg.data;
				default: ;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	// The type byte is the current byte when it is the first data byte.
	assign type_byte = (seen_q == 8'd0) ? byte_s1 : first_q;
	assign seen_inc = seen_q + 8'd1;

	// Parser next state and status for the byte in the input register.
	always_comb begin
		phase_d     = phase_q;
		frame_len_d = frame_len_q;
		seen_d      = seen_q;
		crc_d       = crc_q;
		first_d     = first_q;
		status_d    = ST_PENDING;
		detected_d  = 1'b0;
		unique case (phase_q)
			PH_LENGTH: begin
				if (byte_s1 == 8'd0 || byte_s1 < min_length_q || byte_s1 > max_length_q) begin
					status_d = ST_LEN_REJECT;
					phase_d  = PH_HUNT;
				end else begin
					frame_len_d = byte_s1;
					seen_d      = 8'd0;
					crc_d       = 8'd0;
					phase_d     = PH_DATA;
				end
			end
			PH_DATA: begin
				first_d = type_byte;
				seen_d  = seen_inc;
				if (seen_inc != frame_len_q) begin
					crc_d = crc8_update(crc_q, byte_s1, crc_poly_q);
				end else begin
					phase_d = PH_HUNT;
					priority if (byte_s1 != crc_q) begin
						status_d = ST_CRC_BAD;
					end else if (type_byte != wanted_type_q) begin
						status_d = ST_OTHER_TYPE;
					end else begin
						status_d   = ST_DETECTED;
						detected_d = 1'b1;
					end
				end
			end
			default: begin
				if (byte_s1 == sync_lead_q || byte_s1 == radio_lead_q ||
						byte_s1 == receiver_lead_q) begin
					phase_d = PH_LENGTH;
				end else begin
					phase_d = PH_HUNT;
				end
			end
		endcase
	end

	// Parser state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HUNT;
			frame_len_q <= 8'd0;
			seen_q      <= 8'd0;
			crc_q       <= 8'd0;
			first_q     <= 8'd0;
		end else if (process) begin
			phase_q     <= phase_d;
			frame_len_q <= frame_len_d;
			seen_q      <= seen_d;
			crc_q       <= crc_d;
			first_q     <= first_d;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (process) begin
			status_q   <= status_d;
			detected_q <= detected_d;
		end
	end

	// The detected flag goes with the detected status and nothing else.
	a_det_status: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.detected == (res.status == ST_DETECTED)))
		else $error("detected flag disagrees with status");

	// A byte waiting in the input register is not dropped while the result stalls.
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !res.ready) |=> (valid_s1 && $stable(byte_s1)))
		else $error("input register lost a byte during a stall");

	// Collecting data always works against an accepted, nonzero length.
	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DATA) |-> (frame_len_q != 8'd0 && seen_q < frame_len_q))
		else $error("data phase without room left in the frame");

	// A processed byte always leaves a result behind.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		process |=> out_valid_q)
		else $error("processed byte produced no result");

endmodule
